// ----- hdl/stir_pkg.sv -----
// Package with the shared types, codes and helper function of the sorted table.
package stir_pkg;

    localparam int STIR_CAPACITY = 16;
    localparam int STIR_DATA_W   = 32;
    localparam int STIR_COUNT_W  = 5;
    localparam int STIR_OR_FANIN = 8;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Operation broadcast to every cell of the chain at once.
    typedef struct packed {
        logic                          ins;
        logic                          rem;
        logic signed [STIR_DATA_W-1:0] v;
    } t_cell_op;

    // Number of registered levels an OR tree of the given width needs.
    function automatic int or_levels(input int n);
        int l;
        int span;
        l    = 1;
        span = STIR_OR_FANIN;
        while (span < n) begin
            l    = l + 1;
            span = span * STIR_OR_FANIN;
        end
        return l;
    endfunction

endpackage

// ----- hdl/stir_if.sv -----
// Handshake interfaces for the command channel and the result channel.
interface stir_in_if import stir_pkg::*; ();
    logic                          valid;
    logic                          ready;
    t_cmd                          cmd;
    logic signed [STIR_DATA_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink (input valid, input cmd, input value, output ready);
endinterface

interface stir_out_if import stir_pkg::*; ();
    logic                           valid;
    logic                           ready;
    t_status                        status;
    logic signed [STIR_DATA_W-1:0]  removed_value;
    logic        [STIR_COUNT_W-1:0] count;

    modport source (output valid, output status, output removed_value, output count,
                    input ready);
    modport sink (input valid, input status, input removed_value, input count,
                  output ready);
endinterface

// ----- hdl/stir_cell.sv -----
// One storage cell of the sorted chain: holds a value and trades it with its neighbors.
module stir_cell import stir_pkg::*; (
    input  logic                          i_clk,
    input  t_cell_op                      i_op,
    input  logic                          i_occ,
    input  logic signed [STIR_DATA_W-1:0] i_prev_val,
    input  logic                          i_prev_gt,
    input  logic                          i_prev_ge,
    input  logic signed [STIR_DATA_W-1:0] i_next_val,
    output logic signed [STIR_DATA_W-1:0] o_val,
    output logic                          o_gt,
    output logic                          o_ge,
    output logic                          o_hit
);

    logic signed [STIR_DATA_W-1:0] r_val;
    logic signed [STIR_DATA_W-1:0] n_val;
    logic                          w_en;

    // An empty cell counts as greater, so an insert with no greater value stored lands at the first free cell.
    assign o_gt  = !i_occ || (r_val > i_op.v);
    assign o_ge  = i_occ && (r_val >= i_op.v);
    // The first cell not below the key holds the first equal value, if any.
    assign o_hit = o_ge && !i_prev_ge && (r_val == i_op.v);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        w_en  = 1'b0;
        if (i_op.ins && o_gt) begin
            w_en  = 1'b1;
            n_val = i_prev_gt ? i_prev_val : i_op.v;
        end else if (i_op.rem && o_ge) begin
            w_en  = 1'b1;
            n_val = i_next_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_val <= n_val;
        end
    end

endmodule

// ----- hdl/stir_or_tree.sv -----
// Registered OR tree that tells whether any cell reports a match.
module stir_or_tree import stir_pkg::*; #(
    parameter int N = STIR_CAPACITY
) (
    input  logic         i_clk,
    input  logic [N-1:0] i_bits,
    output logic         o_any
);

    localparam int L = or_levels(N);
    localparam int F = STIR_OR_FANIN;

    logic [N-1:0] w_src [0:L];
    logic [N-1:0] n_lvl [1:L];
    logic [N-1:0] r_lvl [1:L];

    assign w_src[0] = i_bits;

    for (genvar k = 1; k <= L; k++) begin : g_lvl
        assign w_src[k] = r_lvl[k];
        for (genvar j = 0; j < N; j++) begin : g_node
            if (F * j < N) begin : g_used
                localparam int HI = (F * j + F - 1 < N) ? (F * j + F - 1) : (N - 1);
                assign n_lvl[k][j] = |w_src[k-1][HI:F*j];
            end else begin : g_unused
                assign n_lvl[k][j] = 1'b0;
            end
        end
        always_ff @(posedge i_clk) begin
            r_lvl[k] <= n_lvl[k];
        end
    end

    assign o_any = r_lvl[L][0];

endmodule

// ----- hdl/sorted_table_insert_remove.sv -----
// Top level of the sorted table: a chain of compare-and-shift cells with a command sequencer.
// Insert: on acceptance the cells shift and the result is registered at the same clock edge.
// Remove: the key is latched, the search state waits for the match flag of the OR tree, then
// the apply state shifts the cells if a match was found; a waiting result can hold the apply state.
// One command is in flight at a time; a result still waiting at the output holds off the next.
// Reset (synchronous, active low) empties the table and the result register; cell contents stay.
module sorted_table_insert_remove import stir_pkg::*; #(
    parameter int CAPACITY = STIR_CAPACITY
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stir_in_if.sink    i_in,
    stir_out_if.source o_out
);

    // Width of the stored count, which must be able to hold CAPACITY itself.
    localparam int CW = $clog2(CAPACITY + 1);
    // Depth of the match OR tree and the width of the counter that waits for it.
    localparam int L  = or_levels(CAPACITY);
    localparam int WW = $clog2(L) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_APPLY
    } t_state;

    t_state                        r_state;
    logic [CW-1:0]                 r_count;
    logic [WW-1:0]                 r_wait;
    logic signed [STIR_DATA_W-1:0] r_v;

    logic                           r_out_valid;
    logic                           n_out_valid;
    t_status                        r_status;
    logic signed [STIR_DATA_W-1:0]  r_removed;

    t_cell_op                      w_op;
    logic                          w_accept;
    logic                          w_out_free;
    logic                          w_found;

    logic signed [STIR_DATA_W-1:0] w_val [CAPACITY];
    logic [CAPACITY-1:0]           w_gt;
    logic [CAPACITY-1:0]           w_ge;
    logic [CAPACITY-1:0]           w_hit;
    logic [CAPACITY-1:0]           w_occ;

    // The result register may be refilled in the cycle its transaction completes.
    assign w_out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_in.valid && i_in.ready;

    // The cells see the live input value while idle (for inserts), else the latched key.
    always_comb begin
        w_op.v   = (r_state == S_IDLE) ? i_in.value : r_v;
        w_op.ins = w_accept && (i_in.cmd == CMD_INSERT) && (r_count < CW'(CAPACITY));
        w_op.rem = (r_state == S_APPLY) && w_out_free && w_found;
    end

    // A result is produced by an insert or a remove from an empty table at acceptance,
    // or by a remove when it leaves the apply state; otherwise the register drains.
    always_comb begin
        n_out_valid = r_out_valid && !o_out.ready;
        if (w_accept && ((i_in.cmd == CMD_INSERT) || (r_count == '0))) begin
            n_out_valid = 1'b1;
        end
        if ((r_state == S_APPLY) && w_out_free) begin
            n_out_valid = 1'b1;
        end
    end

    // The chain itself. Cell 0 has no left neighbor, so an insert there takes the new value;
    // the last cell has no right neighbor and keeps its own value on a remove.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [STIR_DATA_W-1:0] w_prev_val;
        logic signed [STIR_DATA_W-1:0] w_next_val;
        logic                          w_prev_gt;
        logic                          w_prev_ge;

        assign w_occ[i] = (r_count > CW'(i));

        if (i == 0) begin : g_head
            assign w_prev_val = w_op.v;
            assign w_prev_gt  = 1'b0;
            assign w_prev_ge  = 1'b0;
        end else begin : g_body
            assign w_prev_val = w_val[i-1];
            assign w_prev_gt  = w_gt[i-1];
            assign w_prev_ge  = w_ge[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign w_next_val = w_val[i];
        end else begin : g_inner
            assign w_next_val = w_val[i+1];
        end

        stir_cell u_cell (
            .i_clk      (i_clk),
            .i_op       (w_op),
            .i_occ      (w_occ[i]),
            .i_prev_val (w_prev_val),
            .i_prev_gt  (w_prev_gt),
            .i_prev_ge  (w_prev_ge),
            .i_next_val (w_next_val),
            .o_val      (w_val[i]),
            .o_gt       (w_gt[i]),
            .o_ge       (w_ge[i]),
            .o_hit      (w_hit[i])
        );
    end

    // At most one cell reports a hit; the tree folds them into one registered flag.
    stir_or_tree #(
        .N (CAPACITY)
    ) u_or_tree (
        .i_clk  (i_clk),
        .i_bits (w_hit),
        .o_any  (w_found)
    );

    // Sequencer: state, count and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_wait      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_v    <= i_in.value;
                        r_wait <= '0;
                        if (i_in.cmd == CMD_INSERT) begin
                            // Inserts finish here: the cells shift in this same cycle.
                            r_removed <= '0;
                            if (w_op.ins) begin
                                r_status <= ST_OK;
                                r_count  <= r_count + CW'(1);
                            end else begin
                                r_status <= ST_FULL;
                            end
                        end else if (r_count == '0) begin
                            r_removed <= '0;
                            r_status  <= ST_EMPTY;
                        end else begin
                            r_state <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH: begin
                    // Wait until the last tree level holds the match flag.
                    r_wait <= r_wait + WW'(1);
                    if (r_wait == WW'(L - 1)) begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                        if (w_found) begin
                            // An equal value was found, so it is the key itself.
                            r_status  <= ST_OK;
                            r_removed <= r_v;
                            r_count   <= r_count - CW'(1);
                        end else begin
                            r_status  <= ST_NOT_FOUND;
                            r_removed <= '0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_status;
    assign o_out.removed_value = r_removed;
    assign o_out.count         = STIR_COUNT_W'(r_count);

endmodule

// ----- verif/stir_scoreboard.sv -----
// Scoreboard that predicts every result of the sorted table and checks the result channel.
module stir_scoreboard import stir_pkg::*; #(
    parameter int CAPACITY = STIR_CAPACITY
) (
    input  logic i_clk,
    input  logic i_rst_n,
    stir_in_if   in_ch,
    stir_out_if  out_ch,
    output int   o_errors,
    output int   o_pending
);

    typedef struct {
        t_status                       status;
        logic signed [STIR_DATA_W-1:0] removed_value;
        logic [STIR_COUNT_W-1:0]       count;
    } t_table_result;

    // Shadow copy of the table contents, smallest value first.
    logic signed [STIR_DATA_W-1:0] shadow_vals [CAPACITY];
    int unsigned                   shadow_count;
    t_table_result                 expected_results [$];
    t_table_result                 oldest;

    initial o_errors = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        o_errors = o_errors + 1;
    endtask

    // Applies one command to the shadow table and returns the result it should produce.
    function automatic t_table_result table_update(input t_cmd c,
                                                   input logic signed [STIR_DATA_W-1:0] v);
        t_table_result r;
        int unsigned   pos;
        r.status        = ST_OK;
        r.removed_value = '0;
        pos             = 0;
        if (c == CMD_INSERT) begin
            if (shadow_count >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                while (pos < shadow_count && shadow_vals[pos] <= v)
                    pos++;
                for (int unsigned k = shadow_count; k > pos; k--)
                    shadow_vals[k] = shadow_vals[k-1];
                shadow_vals[pos] = v;
                shadow_count++;
            end
        end else if (shadow_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            while (pos < shadow_count && shadow_vals[pos] != v)
                pos++;
            if (pos >= shadow_count) begin
                r.status = ST_NOT_FOUND;
            end else begin
                r.removed_value = shadow_vals[pos];
                for (int unsigned k = pos; k + 1 < shadow_count; k++)
                    shadow_vals[k] = shadow_vals[k+1];
                shadow_count--;
            end
        end
        r.count = STIR_COUNT_W'(shadow_count);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_count = 0;
            expected_results.delete();
        end else begin
            // A result always belongs to an earlier command, so it is matched first.
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result arrived with no command outstanding");
                end else begin
                    oldest = expected_results.pop_front();
                    if (out_ch.status !== oldest.status
                        || out_ch.removed_value !== oldest.removed_value
                        || out_ch.count !== oldest.count)
                        report_mismatch($sformatf(
                            "got status %0d value %0d count %0d, want %0d %0d %0d",
                            out_ch.status, out_ch.removed_value, out_ch.count,
                            oldest.status, oldest.removed_value, oldest.count));
                end
            end
            if (in_ch.valid && in_ch.ready)
                expected_results.push_back(table_update(in_ch.cmd, in_ch.value));
        end
        o_pending <= expected_results.size();
    end

endmodule

// ----- verif/tb.sv -----
// Testbench top for the sorted table: clock, reset, command stimulus and the verdict.
module tb import stir_pkg::*; ();

    // Inputs change on the falling edge; the scoreboard samples on the rising edge.
    localparam int RANDOM_PER_PHASE = 388;
    localparam int HOLD_CYCLES      = 300;
    // The drain wait is longer than one remove takes.
    localparam int DRAIN_CYCLES     = 20;

    localparam logic signed [STIR_DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [STIR_DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending_count;

    // Share of cycles in percent in which the sender stays idle or the receiver stalls.
    int   sender_idle_pct;
    int   receiver_stall_pct;
    // Set by the stimulus to make the receiver hold off for a long stretch once.
    bit   long_hold_req;

    // Values recently inserted; remove keys are often drawn from here so removes hit.
    logic signed [STIR_DATA_W-1:0] recent_inserts [$];

    stir_in_if  in_ch ();
    stir_out_if out_ch ();

    sorted_table_insert_remove u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    stir_scoreboard u_scoreboard (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .o_errors  (fail_count),
        .o_pending (pending_count)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // The run is ended here if the table stops answering.
    initial begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

    // Receiver: accepts results with a random stall rate. When a long hold is requested,
    // ready is held low so that the result register fills up
    // and the block has to stall the command channel.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                long_hold_req = 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // Small values are drawn often so that duplicates and successful removes are common, with
    // the extremes and full-range values mixed in.
    function automatic logic signed [STIR_DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2, 3, 4, 5: return STIR_DATA_W'($signed($urandom_range(7)) - 4);
            default: return $urandom;
        endcase
    endfunction

    // Offers one command and returns on the rising edge at which the transaction completes.
    // Valid is only lowered when an idle cycle is chosen, never between back-to-back items.
    task automatic send_cmd(input t_cmd c, input logic signed [STIR_DATA_W-1:0] v);
        @(negedge i_clk);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd   <= c;
        in_ch.value <= v;
        do @(posedge i_clk); while (!in_ch.ready);
        if (c == CMD_INSERT) begin
            recent_inserts.push_back(v);
            if (recent_inserts.size() > 16)
                void'(recent_inserts.pop_front());
        end
    endtask

    initial begin
        int   insert_pct;
        t_cmd c;
        logic signed [STIR_DATA_W-1:0] v;

        in_ch.valid        = 1'b0;
        in_ch.cmd          = CMD_INSERT;
        in_ch.value        = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        long_hold_req      = 1'b0;
        insert_pct         = 50;
        i_rst_n            = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: remove from an empty table, the extreme values, an equal value inserted
        // twice, a remove of an absent value, filling the table and an insert into a full table,
        // then removes at both ends.
        send_cmd(CMD_REMOVE, 32'sd3);
        send_cmd(CMD_INSERT, VAL_MAX);
        send_cmd(CMD_INSERT, VAL_MIN);
        send_cmd(CMD_INSERT, 32'sd0);
        send_cmd(CMD_INSERT, -32'sd1);
        send_cmd(CMD_INSERT, 32'sd5);
        send_cmd(CMD_INSERT, 32'sd5);
        send_cmd(CMD_REMOVE, 32'sd5);
        send_cmd(CMD_REMOVE, 32'sd7);
        repeat (STIR_CAPACITY - 5) send_cmd(CMD_INSERT, pick_value());
        send_cmd(CMD_INSERT, 32'sd1);
        send_cmd(CMD_REMOVE, VAL_MIN);
        send_cmd(CMD_REMOVE, VAL_MAX);
        send_cmd(CMD_REMOVE, -32'sd1);

        // Random part in four idling phases. The insert share is redrawn every 32 items so
        // that the table swings between empty and full.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct = 0;  receiver_stall_pct = 0;
                    long_hold_req = 1'b1;
                end
                1: begin sender_idle_pct = 56; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 56; end
                default: begin sender_idle_pct = 18; receiver_stall_pct = 18; end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (n % 32 == 0) begin
                    case ($urandom_range(3))
                        0: insert_pct = 25;
                        1: insert_pct = 50;
                        2: insert_pct = 75;
                        default: insert_pct = 90;
                    endcase
                end
                c = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
                if (c == CMD_REMOVE && recent_inserts.size() != 0 && $urandom_range(1) == 1)
                    v = recent_inserts[$urandom_range(recent_inserts.size() - 1)];
                else
                    v = pick_value();
                send_cmd(c, v);
            end
        end

        @(negedge i_clk);
        in_ch.valid <= 1'b0;

        // Wait for every outstanding result, then a little longer for strays.
        do @(posedge i_clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/stir_pkg.sv
hdl/stir_if.sv
hdl/stir_cell.sv
hdl/stir_or_tree.sv
hdl/sorted_table_insert_remove.sv
verif/stir_scoreboard.sv
verif/tb.sv
